### rtl/core/swpp_pkg.sv
`default_nettype none

package swpp_pkg;

  // Default number of stack entries.
  localparam int SWPP_DEPTH = 8;

  // Operation codes carried on the input channel.
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;
  localparam logic [1:0] OP_PEEK    = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // Read address selection for the store.
  localparam logic [1:0] RA_TOP  = 2'd0;
  localparam logic [1:0] RA_PART = 2'd1;
  localparam logic [1:0] RA_EMIT = 2'd2;

  // Write port selection for the store.
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_PUSH = 2'd1;
  localparam logic [1:0] WR_LOW  = 2'd2;
  localparam logic [1:0] WR_HIGH = 2'd3;

  // Result data selection.
  localparam logic OD_ZERO = 1'b0;
  localparam logic OD_READ = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic [1:0] wr_sel;
    logic       i_inc;
    logic       t_dec;
    logic       j_dec;
    logic       fill_inc;
    logic       fill_dec;
    logic       out_load;
    logic [1:0] out_status;
    logic       out_dsel;
    logic       out_last;
  } swpp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       i_le_t;
    logic       t_zero;
    logic       low_even;
    logic       j_one;
    logic       out_free;
  } swpp_stat_t;

endpackage

`default_nettype wire

### rtl/core/swpp_dpath.sv
`default_nettype none

module swpp_dpath
  import swpp_pkg::*;
#(
  parameter int DEPTH = SWPP_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swpp_cmd_t          cmd,
  output swpp_stat_t              stat,
  input  wire logic [1:0]         in_op,
  input  wire logic signed [31:0] in_value,
  input  wire logic               out_tready,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_data,
  output logic                    out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_a_r;
  logic [31:0]   rd_b_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] t_r;
  logic [CW-1:0] j_r;
  logic [1:0]    op_r;
  logic [31:0]   val_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_data_r;
  logic          out_last_r;

  logic [CW-1:0] top_idx;
  logic [CW-1:0] emit_idx;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // Read addresses: top of stack, the two partition cursors, or the display cursor.
  assign top_idx  = fill_r - CW'(1);
  assign emit_idx = j_r - CW'(1);
  assign addr_b   = t_r[AW-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RA_TOP:  addr_a = top_idx[AW-1:0];
      RA_PART: addr_a = i_r[AW-1:0];
      RA_EMIT: addr_a = emit_idx[AW-1:0];
      default: addr_a = top_idx[AW-1:0];
    endcase
  end

  // Write port: a push, or one half of a partition swap.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = fill_r[AW-1:0];
    wr_data = val_r;
    unique case (cmd.wr_sel)
      WR_NONE: wr_en = 1'b0;
      WR_PUSH: begin
        wr_addr = fill_r[AW-1:0];
        wr_data = val_r;
      end
      WR_LOW: begin
        wr_addr = i_r[AW-1:0];
        wr_data = rd_b_r;
      end
      WR_HIGH: begin
        wr_addr = t_r[AW-1:0];
        wr_data = rd_a_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Stack store with two registered read ports and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  // Captured operation and pushed word.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= in_op;
      val_r <= in_value;
    end
  end

  // Fill count and walk cursors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      i_r    <= '0;
      t_r    <= '0;
      j_r    <= '0;
    end else begin
      if (cmd.fill_inc) begin
        fill_r <= fill_r + CW'(1);
      end else if (cmd.fill_dec) begin
        fill_r <= fill_r - CW'(1);
      end
      if (cmd.take) begin
        i_r <= '0;
        t_r <= top_idx;
        j_r <= fill_r;
      end else begin
        if (cmd.i_inc) begin
          i_r <= i_r + CW'(1);
        end
        if (cmd.t_dec) begin
          t_r <= t_r - CW'(1);
        end
        if (cmd.j_dec) begin
          j_r <= emit_idx;
        end
      end
    end
  end

  // Output register; a loaded result stays until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_data_r   <= (cmd.out_dsel == OD_READ) ? rd_a_r : 32'd0;
      out_last_r   <= cmd.out_last;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.op       = op_r;
    stat.empty    = (fill_r == '0);
    stat.full     = (fill_r == CW'(DEPTH));
    stat.i_le_t   = (i_r <= t_r);
    stat.t_zero   = (t_r == '0);
    stat.low_even = ~rd_a_r[0];
    stat.j_one    = (j_r == CW'(1));
    stat.out_free = ~out_valid_r | out_tready;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

### rtl/core/swpp_ctrl.sv
`default_nettype none

module swpp_ctrl
  import swpp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  output logic            in_ready,
  input  wire swpp_stat_t stat,
  output swpp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RESP = 3'd1;
  localparam logic [2:0] S_PRD  = 3'd2;
  localparam logic [2:0] S_PDEC = 3'd3;
  localparam logic [2:0] S_PSWP = 3'd4;
  localparam logic [2:0] S_ERD  = 3'd5;
  localparam logic [2:0] S_EOUT = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RA_TOP;
    cmd.wr_sel     = WR_NONE;
    cmd.out_status = ST_OK;
    cmd.out_dsel   = OD_ZERO;
    unique case (state_r)
      S_IDLE: begin
        // Keep the top entry read so pop and peek have it on the next cycle.
        in_ready   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_TOP;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_op == OP_DISPLAY && !stat.empty) begin
            state_nxt = S_PRD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          unique case (stat.op)
            OP_PUSH: begin
              if (stat.full) begin
                cmd.out_status = ST_OVERFLOW;
              end else begin
                cmd.wr_sel   = WR_PUSH;
                cmd.fill_inc = 1'b1;
              end
            end
            OP_POP: begin
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.fill_dec = 1'b1;
                cmd.out_dsel = OD_READ;
              end
            end
            OP_PEEK: begin
              if (stat.empty) begin
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.out_dsel = OD_READ;
              end
            end
            default: begin
              // Display reaches here only on an empty stack.
              cmd.out_status = ST_EMPTY;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_PRD: begin
        // Fetch both cursor entries while the cursors have not crossed.
        if (stat.i_le_t) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_PART;
          state_nxt  = S_PDEC;
        end else begin
          state_nxt = S_ERD;
        end
      end
      S_PDEC: begin
        // An even low entry is swapped with the high entry; an odd one stays.
        if (stat.low_even) begin
          cmd.wr_sel = WR_LOW;
          state_nxt  = S_PSWP;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PSWP: begin
        // Second half of the swap; the walk stops once the high cursor is at the bottom.
        cmd.wr_sel = WR_HIGH;
        if (stat.t_zero) begin
          state_nxt = S_ERD;
        end else begin
          cmd.t_dec = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_ERD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_EMIT;
        state_nxt  = S_EOUT;
      end
      S_EOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_dsel = OD_READ;
          cmd.out_last = stat.j_one;
          cmd.j_dec    = 1'b1;
          state_nxt    = stat.j_one ? S_IDLE : S_ERD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/stack_with_parity_partition_top.sv
`default_nettype none

// Push, pop and peek are accepted in the idle state, then the response state loads the
// output register once it is free; the result is visible on the cycle after that load.
// Display on a non-empty stack runs the partition walk over the single-write-port
// store (a swap needs two writes), then emits each entry from top to bottom.
// Reset clears the fill count, cursors, controller and output valid; no clearing pass.
module stack_with_parity_partition_top
  import swpp_pkg::*;
#(
  parameter int DEPTH = SWPP_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] data
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast
);

  swpp_cmd_t  cmd;
  swpp_stat_t stat;

  // Operation sequencing.
  swpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, cursors and output register.
  swpp_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_value   (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_data   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

### test/stack_with_parity_partition_checker.sv
`default_nettype none

// Watches both stream channels of the parity partition stack, keeps a shadow copy
// of the stack, and compares every result transfer with the oldest awaited result.
module stack_with_parity_partition_checker
  import swpp_pkg::*;
#(
  parameter int DEPTH = SWPP_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // [31:0] data
  input  wire logic [1:0]  out_tuser,  // [1:0] status
  input  wire logic        out_tlast,
  output int               mismatch_count,
  output int               results_due
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic        last;
  } stack_result_t;

  // Shadow copy of the stack contents and its fill level.
  logic [31:0]   shadow_words [DEPTH];
  int            shadow_fill;
  stack_result_t awaited_results [$];
  int            error_total;

  function automatic void await_result(logic [1:0] status, logic [31:0] data, logic last);
    stack_result_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  // Two-cursor walk: an even word at the low cursor is swapped with the word at
  // the high cursor, which then moves down; an odd word lets the low cursor climb.
  function automatic void partition_by_parity();
    int          lo;
    int          hi;
    logic [31:0] tmp;
    lo = 0;
    hi = shadow_fill - 1;
    while (lo <= hi) begin
      if (!shadow_words[lo][0]) begin
        tmp              = shadow_words[lo];
        shadow_words[lo] = shadow_words[hi];
        shadow_words[hi] = tmp;
        hi--;
      end else begin
        lo++;
      end
    end
  endfunction

  // Applies one accepted operation to the shadow stack and queues its results.
  function automatic void run_stack_op(logic [1:0] op, logic [31:0] word);
    case (op)
      OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          await_result(ST_OVERFLOW, 32'd0, 1'b1);
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
          await_result(ST_OK, 32'd0, 1'b1);
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          await_result(ST_EMPTY, 32'd0, 1'b1);
        end else begin
          shadow_fill--;
          await_result(ST_OK, shadow_words[shadow_fill], 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (shadow_fill == 0) begin
          await_result(ST_EMPTY, 32'd0, 1'b1);
        end else begin
          partition_by_parity();
          for (int j = shadow_fill - 1; j >= 0; j--) begin
            await_result(ST_OK, shadow_words[j], (j == 0));
          end
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          await_result(ST_EMPTY, 32'd0, 1'b1);
        end else begin
          await_result(ST_OK, shadow_words[shadow_fill - 1], 1'b1);
        end
      end
    endcase
  endfunction

  // Compares one result transfer with the oldest awaited result.
  function automatic void check_result();
    stack_result_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: status %0d, data %h, last %0b",
             out_tuser, out_tdata, out_tlast);
      error_total++;
    end else begin
      want = awaited_results.pop_front();
      if (out_tuser !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser);
        error_total++;
      end
      if (out_tdata !== want.data) begin
        $error("data mismatch: expected %h, actual %h", want.data, out_tdata);
        error_total++;
      end
      if (out_tlast !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, out_tlast);
        error_total++;
      end
    end
  endfunction

  // Results are checked before the input of the same edge is applied; a result can
  // never stem from an item accepted at that very edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      error_total = 0;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_result();
      end
      if (in_tvalid && in_tready) begin
        run_stack_op(in_tuser, in_tdata);
      end
    end
    mismatch_count <= error_total;
    results_due    <= awaited_results.size();
  end

endmodule

`default_nettype wire

### test/tb_stack_with_parity_partition_top.sv
`default_nettype none

// Drives operations into the parity partition stack with random idling on both
// channels and reports the verdict from the checker's counts.
module tb_stack_with_parity_partition_top
  import swpp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          mismatch_count;
  int          results_due;
  bit          sender_idles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stack_with_parity_partition_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  stack_with_parity_partition_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  // Offers one operation and holds it until the transfer happens.
  task automatic send_op(input logic [1:0] op, input logic [31:0] word);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random gap after a transfer: mostly none or short, now and then long.
  task automatic sender_gap();
    int roll;
    int cycles;
    roll   = $urandom_range(0, 99);
    cycles = 0;
    if (sender_idles) begin
      if (roll >= 92) cycles = $urandom_range(8, 40);
      else if (roll >= 60) cycles = $urandom_range(1, 3);
    end
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Holds the sender off until every awaited result has arrived.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Push values mostly random, sometimes at the extremes of the word.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Result side: stretches of steady readiness alternate with random stalls.
  initial begin : ready_gen
    int  stretch;
    bit  stalls;
    out_tready <= 1'b0;
    stretch = 0;
    stalls  = 1'b0;
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        stretch = $urandom_range(20, 120);
        stalls  = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      if (!stalls) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Stimulus: directed corner cases, then phases of biased random operations.
  initial begin : stimulus
    int         push_pct;
    int         roll;
    logic [1:0] op;
    in_tvalid    <= 1'b0;
    in_tdata     <= 32'd0;
    in_tuser     <= OP_PUSH;
    rst_n        <= 1'b0;
    sender_idles = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack on pop, peek and display.
    send_op(OP_POP, 32'hFFFF_FFFF);      sender_gap();
    send_op(OP_PEEK, 32'h0000_0000);     sender_gap();
    send_op(OP_DISPLAY, 32'hA5A5_5A5A);  sender_gap();
    // Fill to the top with a mix of odd, even and extreme words.
    send_op(OP_PUSH, 32'h8000_0000);     sender_gap();
    send_op(OP_PUSH, 32'h7FFF_FFFF);     sender_gap();
    send_op(OP_PUSH, 32'h0000_0000);     sender_gap();
    send_op(OP_PUSH, 32'hFFFF_FFFF);     sender_gap();
    send_op(OP_PUSH, 32'h0000_0002);     sender_gap();
    send_op(OP_PUSH, 32'h0000_0001);     sender_gap();
    send_op(OP_PUSH, 32'hFFFF_FFFE);     sender_gap();
    send_op(OP_PUSH, 32'h5555_5555);     sender_gap();
    // Push on a full stack must overflow and leave the store alone.
    send_op(OP_PUSH, 32'hAAAA_AAAA);     sender_gap();
    send_op(OP_PEEK, 32'h1234_5678);     sender_gap();
    send_op(OP_DISPLAY, 32'h0000_0000);  sender_gap();
    send_op(OP_POP, 32'h0000_0000);      sender_gap();
    send_op(OP_DISPLAY, 32'hFFFF_FFFF);  sender_gap();
    send_op(OP_PEEK, 32'h0000_0000);     sender_gap();
    // Single entry, then one odd and one even entry.
    repeat (6) begin
      send_op(OP_POP, $urandom);         sender_gap();
    end
    send_op(OP_DISPLAY, $urandom);       sender_gap();
    send_op(OP_PUSH, 32'h0000_0010);     sender_gap();
    send_op(OP_DISPLAY, $urandom);
    drain_results();

    // Random phases, each push-heavy, pop-heavy or balanced, picked at random.
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 30;
        default: push_pct = 55;
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      repeat (20) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          op = OP_PUSH;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_POP;
            4, 5, 6:    op = OP_DISPLAY;
            default:    op = OP_PEEK;
          endcase
        end
        send_op(op, (op == OP_PUSH) ? pick_word() : $urandom);
        sender_gap();
      end
      if (phase == 4) begin
        drain_results();
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("stack_with_parity_partition_top regression: pass");
    end else begin
      $display("stack_with_parity_partition_top regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("stack_with_parity_partition_top regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
